@@ rtl/rdr_pkg.sv @@
package rdr_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_CIRCUIT_OPEN = 3'd0;
    localparam logic [2:0] REG_FALLBACK_IP  = 3'd1;
    localparam logic [2:0] REG_FALLBACK_MAC = 3'd2;
    localparam logic [2:0] REG_FIRST_PORT   = 3'd3;
    localparam logic [2:0] REG_SECOND_PORT  = 3'd4;

    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 48;
    localparam int TDATA_W = 40;

    localparam logic [15:0] FIRST_PORT_RESET  = 16'd8000;
    localparam logic [15:0] SECOND_PORT_RESET = 16'd50051;
    localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
    localparam logic [7:0]  PROTO_TCP         = 8'd6;
    localparam logic [15:0] ONES16            = 16'hffff;

    // Byte counts that bound the decision point
    localparam logic [7:0] IHL_BYTE_AVAIL = 8'd15;
    localparam logic [7:0] TCP_HDR_END    = 8'd34;

    // Header words (cells) that hold fields of interest
    localparam int CELL_MAC_HI    = 0;
    localparam int CELL_MAC_LO    = 1;
    localparam int CELL_ETHTYPE   = 3;
    localparam int CELL_PORT_BASE = 4;
    localparam int CELL_PROTO     = 5;
    localparam int CELL_CSUM      = 6;
    localparam int CELL_IP_HI     = 7;
    localparam int CELL_IP_LO     = 8;

    typedef struct packed {
        logic        hit;
        logic [15:0] csum;
        logic [3:0]  ihl;
    } rdr_dec_t;

    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  mask;
    } rdr_patch_t;

    function automatic logic [2:0] norm_bytes(logic [2:0] b);
        logic [2:0] r;
        r = b;
        if (b == 3'd0 || b > 3'd4)
        begin
            r = 3'd4;
        end
        return r;
    endfunction

    // Byte lanes of one header word that a redirect overwrites; mask bit 3 is the earliest byte
    function automatic rdr_patch_t patch_for(int idx, logic [47:0] mac, logic [31:0] ip,
                                             logic [15:0] csum);
        rdr_patch_t p;
        p.word = 32'd0;
        p.mask = 4'b0000;
        case (idx)
            CELL_MAC_HI:
            begin
                p.word = mac[47:16];
                p.mask = 4'b1111;
            end
            CELL_MAC_LO:
            begin
                p.word = {mac[15:0], 16'd0};
                p.mask = 4'b1100;
            end
            CELL_CSUM:
            begin
                p.word = {csum, 16'd0};
                p.mask = 4'b1100;
            end
            CELL_IP_HI:
            begin
                p.word = {16'd0, ip[31:16]};
                p.mask = 4'b0011;
            end
            CELL_IP_LO:
            begin
                p.word = {ip[15:0], 16'd0};
                p.mask = 4'b1100;
            end
            default:
            begin
                p.mask = 4'b0000;
            end
        endcase
        return p;
    endfunction

endpackage

@@ rtl/tcp_port_redirect_rewriter_core.sv @@
// TCP destination redirect with incremental IPv4 checksum patch.
// Slave stream: one 32-bit frame word per transfer (earliest byte in bits 31:24),
// byte count in tdata[34:32], tlast on the final word. Master stream: the same
// words after any rewrite, with the frame verdict in tuser (1 = redirected).
// Each header transfer is stored in one of a row of word cells, and input is
// held off while a check state tests whether the decision point is reached. At
// the decision a redirected frame has its destination MAC, IPv4 address and
// header checksum patched in place, and the cells shift out through the output
// register one word per cycle while the master side accepts, with input held
// off. The rest of the frame then streams at one word per cycle while the
// master side accepts. A frame that ends before the decision point is flushed
// unchanged. Past the header, a stalled master side holds the output register
// and backpressures the slave side once it is full. Reset empties the cells and
// output register and loads register defaults (ports 8000 and 50051, circuit
// closed). Configuration writes are taken at any cycle and belong between frames.
module tcp_port_redirect_rewriter_core
    import rdr_pkg::*;
#(
    parameter int HEADER_WORDS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // [31:0] word_in, [34:32] bytes_in
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // [31:0] word_out, [34:32] bytes_out
    output logic                m_tlast,
    output logic                m_tuser,   // [0] verdict
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata
);

    localparam int IDXW = $clog2(HEADER_WORDS);
    localparam int CNTW = $clog2(HEADER_WORDS + 1);
    localparam int AVW  = CNTW + 3;

    localparam logic [1:0] S_COLLECT = 2'd0;
    localparam logic [1:0] S_CHECK   = 2'd1;
    localparam logic [1:0] S_FLUSH   = 2'd2;
    localparam logic [1:0] S_STREAM  = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            last_reg, last_next;
    logic [2:0]      lastb_reg, lastb_next;
    logic            verdict_reg, verdict_next;
    logic            flast_reg, flast_next;

    logic            circuit_open_reg;
    logic [31:0]     fallback_ip_reg;
    logic [47:0]     fallback_mac_reg;
    logic [15:0]     first_port_reg;
    logic [15:0]     second_port_reg;

    logic            ovalid_reg, ovalid_next;
    logic [31:0]     oword_reg, oword_next;
    logic [2:0]      obytes_reg, obytes_next;
    logic            olast_reg, olast_next;
    logic            overdict_reg, overdict_next;

    logic            can_load;
    logic            in_xfer;
    logic [2:0]      in_bytes;
    logic            load;
    logic            shift;
    logic            rewrite;
    logic [31:0]     cell_word [HEADER_WORDS];
    logic [2:0]      head_bytes;
    rdr_dec_t        dec;
    logic [AVW-1:0]  avail;
    logic [AVW-1:0]  needed;
    logic            enough;

    assign can_load = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == S_COLLECT) || ((state_reg == S_STREAM) && can_load);
    assign in_xfer  = s_tvalid && s_tready;
    assign in_bytes = norm_bytes(s_tdata[34:32]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circuit_open_reg <= 1'b0;
            fallback_ip_reg  <= 32'd0;
            fallback_mac_reg <= 48'd0;
            first_port_reg   <= FIRST_PORT_RESET;
            second_port_reg  <= SECOND_PORT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CIRCUIT_OPEN: circuit_open_reg <= cfg_wdata[0];
                REG_FALLBACK_IP:  fallback_ip_reg  <= cfg_wdata[31:0];
                REG_FALLBACK_MAC: fallback_mac_reg <= cfg_wdata[47:0];
                REG_FIRST_PORT:   first_port_reg   <= cfg_wdata[15:0];
                REG_SECOND_PORT:  second_port_reg  <= cfg_wdata[15:0];
                default:          ;
            endcase
        end
    end

    rdr_chain #(
        .N (HEADER_WORDS)
    ) u_chain (
        .clk        (clk),
        .load       (load),
        .load_idx   (count_reg[IDXW-1:0]),
        .load_word  (s_tdata[31:0]),
        .load_bytes (in_bytes),
        .shift      (shift),
        .rewrite    (rewrite),
        .mac        (fallback_mac_reg),
        .ip         (fallback_ip_reg),
        .csum       (dec.csum),
        .cell_word  (cell_word),
        .head_bytes (head_bytes)
    );

    rdr_decide #(
        .N (HEADER_WORDS)
    ) u_decide (
        .cell_word    (cell_word),
        .circuit_open (circuit_open_reg),
        .fallback_ip  (fallback_ip_reg),
        .first_port   (first_port_reg),
        .second_port  (second_port_reg),
        .dec          (dec)
    );

    // Bytes held so far; only the last word's count shortens the frame
    assign avail  = last_reg ? (AVW'(count_reg - 1'b1) << 2) + AVW'(lastb_reg)
                             : AVW'(count_reg) << 2;
    assign needed = AVW'(TCP_HDR_END) + (AVW'(dec.ihl) << 2);
    assign enough = avail >= needed;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        lastb_next    = lastb_reg;
        verdict_next  = verdict_reg;
        flast_next    = flast_reg;
        ovalid_next   = ovalid_reg && !m_tready;
        oword_next    = oword_reg;
        obytes_next   = obytes_reg;
        olast_next    = olast_reg;
        overdict_next = overdict_reg;
        load          = 1'b0;
        shift         = 1'b0;
        rewrite       = 1'b0;

        unique case (state_reg)
            S_COLLECT:
            begin
                if (in_xfer)
                begin
                    load       = 1'b1;
                    count_next = count_reg + 1'b1;
                    last_next  = s_tlast;
                    lastb_next = in_bytes;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((avail >= AVW'(IHL_BYTE_AVAIL))
                    && (enough || (count_reg >= CNTW'(HEADER_WORDS))))
                begin
                    verdict_next = enough && dec.hit;
                    rewrite      = enough && dec.hit;
                    flast_next   = last_reg;
                    state_next   = S_FLUSH;
                end
                else if (last_reg)
                begin
                    verdict_next = 1'b0;
                    flast_next   = 1'b1;
                    state_next   = S_FLUSH;
                end
                else
                begin
                    state_next = S_COLLECT;
                end
            end
            S_FLUSH:
            begin
                if (can_load)
                begin
                    shift         = 1'b1;
                    ovalid_next   = 1'b1;
                    oword_next    = cell_word[0];
                    obytes_next   = head_bytes;
                    olast_next    = flast_reg && (count_reg == CNTW'(1));
                    overdict_next = verdict_reg;
                    count_next    = count_reg - 1'b1;
                    if (count_reg == CNTW'(1))
                    begin
                        // Frame fully out or continue with the body
                        state_next   = flast_reg ? S_COLLECT : S_STREAM;
                        verdict_next = flast_reg ? 1'b0 : verdict_reg;
                    end
                end
            end
            S_STREAM:
            begin
                if (in_xfer)
                begin
                    ovalid_next   = 1'b1;
                    oword_next    = s_tdata[31:0];
                    obytes_next   = in_bytes;
                    olast_next    = s_tlast;
                    overdict_next = verdict_reg;
                    if (s_tlast)
                    begin
                        state_next   = S_COLLECT;
                        verdict_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_COLLECT;
            count_reg   <= '0;
            last_reg    <= 1'b0;
            lastb_reg   <= 3'd4;
            verdict_reg <= 1'b0;
            flast_reg   <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            last_reg    <= last_next;
            lastb_reg   <= lastb_next;
            verdict_reg <= verdict_next;
            flast_reg   <= flast_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oword_reg    <= oword_next;
        obytes_reg   <= obytes_next;
        olast_reg    <= olast_next;
        overdict_reg <= overdict_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{(TDATA_W - 35){1'b0}}, obytes_reg, oword_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = overdict_reg;

`ifndef SYNTHESIS
    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLUSH |-> count_reg != '0)
        else $error("flush with no held header words");

    a_store_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COLLECT) && s_tvalid && s_tready |=> state_reg == S_CHECK)
        else $error("stored header word not checked");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(HEADER_WORDS))
        else $error("header word count beyond store depth");

    a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) || (state_reg == S_CHECK) |-> !s_tready)
        else $error("input taken while header is pending");
`endif

endmodule

@@ rtl/rdr_cell.sv @@
module rdr_cell
    import rdr_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic        shift,
    input  logic        patch,
    input  logic [31:0] load_word,
    input  logic [2:0]  load_bytes,
    input  logic [31:0] nbr_word,
    input  logic [2:0]  nbr_bytes,
    input  rdr_patch_t  patch_data,
    output logic [31:0] word,
    output logic [2:0]  bytes
);

    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic [2:0]  bytes_reg;
    logic [2:0]  bytes_next;

    always_comb
    begin
        word_next  = word_reg;
        bytes_next = bytes_reg;
        if (load)
        begin
            word_next  = load_word;
            bytes_next = load_bytes;
        end
        else if (shift)
        begin
            word_next  = nbr_word;
            bytes_next = nbr_bytes;
        end
        else if (patch)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if (patch_data.mask[b])
                begin
                    word_next[b*8 +: 8] = patch_data.word[b*8 +: 8];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        bytes_reg <= bytes_next;
    end

    assign word  = word_reg;
    assign bytes = bytes_reg;

endmodule

@@ rtl/rdr_chain.sv @@
module rdr_chain
    import rdr_pkg::*;
#(
    parameter int N = 24
)
(
    input  logic                 clk,
    input  logic                 load,
    input  logic [$clog2(N)-1:0] load_idx,
    input  logic [31:0]          load_word,
    input  logic [2:0]           load_bytes,
    input  logic                 shift,
    input  logic                 rewrite,
    input  logic [47:0]          mac,
    input  logic [31:0]          ip,
    input  logic [15:0]          csum,
    output logic [31:0]          cell_word [N],
    output logic [2:0]           head_bytes
);

    logic [2:0] cell_bytes [N];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            localparam int NB = (i == N - 1) ? i : i + 1;
            rdr_patch_t pd;
            logic       pen;

            assign pd  = patch_for(i, mac, ip, csum);
            assign pen = rewrite && (pd.mask != 4'b0000);

            rdr_cell u_cell (
                .clk        (clk),
                .load       (load && (load_idx == ($clog2(N))'(i))),
                .shift      (shift),
                .patch      (pen),
                .load_word  (load_word),
                .load_bytes (load_bytes),
                .nbr_word   (cell_word[NB]),
                .nbr_bytes  (cell_bytes[NB]),
                .patch_data (pd),
                .word       (cell_word[i]),
                .bytes      (cell_bytes[i])
            );
        end
    endgenerate

    assign head_bytes = cell_bytes[0];

endmodule

@@ rtl/rdr_decide.sv @@
module rdr_decide
    import rdr_pkg::*;
#(
    parameter int N = 24
)
(
    input  logic [31:0] cell_word [N],
    input  logic        circuit_open,
    input  logic [31:0] fallback_ip,
    input  logic [15:0] first_port,
    input  logic [15:0] second_port,
    output rdr_dec_t    dec
);

    logic [3:0]  ihl;
    logic [15:0] dport;
    logic [15:0] hc;
    logic [15:0] old_hi;
    logic [15:0] old_lo;
    logic [18:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic        is_ipv4;
    logic        is_tcp;
    logic        port_hit;

    assign ihl = cell_word[CELL_ETHTYPE][11:8];

    // TCP destination port sits in the upper half of header word 4 + IHL
    always_comb
    begin
        dport = 16'd0;
        for (int k = 0; k < 16; k++)
        begin
            if (ihl == 4'(k))
            begin
                dport = cell_word[CELL_PORT_BASE + k][31:16];
            end
        end
    end

    assign is_ipv4  = cell_word[CELL_ETHTYPE][31:16] == ETHERTYPE_IPV4;
    assign is_tcp   = cell_word[CELL_PROTO][7:0] == PROTO_TCP;
    assign port_hit = (dport == first_port) || (dport == second_port);

    assign hc     = cell_word[CELL_CSUM][31:16];
    assign old_hi = cell_word[CELL_IP_HI][15:0];
    assign old_lo = cell_word[CELL_IP_LO][31:16];

    // HC' = ~(~HC + ~m + m') with end-around carry
    assign sum   = 19'(hc ^ ONES16) + 19'(old_hi ^ ONES16) + 19'(old_lo ^ ONES16)
                 + 19'(fallback_ip[31:16]) + 19'(fallback_ip[15:0]);
    assign fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    assign dec.hit  = is_ipv4 && is_tcp && port_hit && circuit_open;
    assign dec.csum = fold2 ^ ONES16;
    assign dec.ihl  = ihl;

endmodule

@@ sim/tcp_port_redirect_rewriter_core_tb.sv @@
`timescale 1ns / 100ps

module tcp_port_redirect_rewriter_core_tb;
    import rdr_pkg::*;

    localparam int   HDR_DEPTH        = 24;
    localparam int   CYCLE_LIMIT      = 200000;
    localparam int   SETTLE_CYCLES    = 32;
    localparam int   END_WAIT_LIMIT   = 20000;
    localparam int   MAX_PRINTED      = 40;
    localparam logic VERDICT_PASS     = 1'b0;
    localparam logic VERDICT_REDIRECT = 1'b1;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
        logic        verdict;
    } frame_word_t;

    typedef logic [7:0] byte_q_t[$];

    typedef enum int {
        FK_PORT_A,
        FK_PORT_B,
        FK_OTHER_PORT,
        FK_NOT_IPV4,
        FK_NOT_TCP,
        FK_NOISE
    } frame_kind_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;   // [31:0] word_in, [34:32] bytes_in
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;   // [31:0] word_out, [34:32] bytes_out
    logic                m_tlast;
    logic                m_tuser;   // [0] verdict
    logic                cfg_we;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [CFG_DW-1:0]   cfg_wdata;

    tcp_port_redirect_rewriter_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor copy of the header buffer, frame state and registers
    logic [31:0] held_word [HDR_DEPTH];
    logic [2:0]  held_bytes [HDR_DEPTH];
    int          held_count;
    bit          streaming;
    logic        frame_verdict;
    logic        circ_open;
    logic [31:0] new_ip;
    logic [47:0] new_mac;
    logic [15:0] port_a;
    logic [15:0] port_b;

    frame_word_t expected_words[$];
    frame_word_t want_word;

    int errors            = 0;
    int words_sent        = 0;
    int frames_sent       = 0;
    int frames_redirected = 0;
    int words_checked     = 0;
    int cycles            = 0;
    int rx_hold           = 0;
    bit no_idle           = 1'b0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_words.size());
            $display("tcp_port_redirect_rewriter_core_tb NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        errors++;
        if (errors <= MAX_PRINTED)
        begin
            $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        end
    endtask

    function automatic logic [7:0] hdr_byte(int pos);
        logic [31:0] w;
        if ((pos >> 2) >= HDR_DEPTH)
        begin
            return 8'd0;
        end
        w = held_word[pos >> 2];
        return w[(3 - (pos & 3)) * 8 +: 8];
    endfunction

    function automatic logic [15:0] hdr_half(int pos);
        return {hdr_byte(pos), hdr_byte(pos + 1)};
    endfunction

    function automatic void set_hdr_byte(int pos, logic [7:0] v);
        held_word[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = v;
    endfunction

    // Advance the predictor by one accepted word and queue the words it releases
    function automatic void predict_transfer(logic [31:0] word, logic [2:0] raw_bytes,
                                             logic last);
        logic [2:0]  nb;
        logic [7:0]  vihl;
        logic [15:0] dport;
        logic [15:0] hc_n;
        logic [15:0] ip_hi_n;
        logic [15:0] ip_lo_n;
        logic [31:0] csum_acc;
        int          avail;
        int          needed;
        int          toff;
        int          i;
        bit          decided;
        frame_word_t fw;
        nb = (raw_bytes == 3'd0 || raw_bytes > 3'd4) ? 3'd4 : raw_bytes;
        if (streaming)
        begin
            fw = '{word, nb, last, frame_verdict};
            expected_words.push_back(fw);
            if (last)
            begin
                streaming = 1'b0;
                frame_verdict = VERDICT_PASS;
            end
            return;
        end
        if (held_count >= HDR_DEPTH)
        begin
            held_count = 0;
        end
        held_word[held_count] = word;
        held_bytes[held_count] = nb;
        held_count++;
        // byte positions advance by 4 per word; only the last word's count trims
        avail = last ? (held_count - 1) * 4 + int'(nb) : held_count * 4;
        decided = 1'b0;
        if (avail >= 15)
        begin
            vihl = hdr_byte(14);
            toff = 14 + 4 * int'(vihl[3:0]);
            needed = (toff + 20 < 34) ? 34 : toff + 20;
            if (avail >= needed || held_count >= HDR_DEPTH)
            begin
                decided = 1'b1;
                frame_verdict = VERDICT_PASS;
                if (avail >= needed)
                begin
                    dport = hdr_half(toff + 2);
                    if (hdr_half(12) == ETHERTYPE_IPV4 && hdr_byte(23) == PROTO_TCP &&
                        (dport == port_a || dport == port_b) && circ_open)
                    begin
                        frame_verdict = VERDICT_REDIRECT;
                    end
                end
                if (frame_verdict == VERDICT_REDIRECT)
                begin
                    // incremental update: HC' = ~(~HC + ~m + m') over both address halves
                    hc_n = ~hdr_half(24);
                    ip_hi_n = ~hdr_half(30);
                    ip_lo_n = ~hdr_half(32);
                    csum_acc = 32'(hc_n) + 32'(ip_hi_n) + 32'(ip_lo_n)
                             + 32'(new_ip[31:16]) + 32'(new_ip[15:0]);
                    csum_acc = (csum_acc >> 16) + (csum_acc & 32'h0000_ffff);
                    csum_acc = csum_acc + (csum_acc >> 16);
                    for (i = 0; i < 6; i++)
                    begin
                        set_hdr_byte(i, new_mac[(5 - i) * 8 +: 8]);
                    end
                    for (i = 0; i < 4; i++)
                    begin
                        set_hdr_byte(30 + i, new_ip[(3 - i) * 8 +: 8]);
                    end
                    set_hdr_byte(24, ~csum_acc[15:8]);
                    set_hdr_byte(25, ~csum_acc[7:0]);
                    frames_redirected++;
                end
            end
        end
        if (decided || last)
        begin
            for (i = 0; i < held_count; i++)
            begin
                fw = '{held_word[i], held_bytes[i], last && (i == held_count - 1),
                       decided ? frame_verdict : VERDICT_PASS};
                expected_words.push_back(fw);
            end
            held_count = 0;
            streaming = decided && !last;
            if (!streaming)
            begin
                frame_verdict = VERDICT_PASS;
            end
        end
    endfunction

    // Check every output transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected output word", 48'(m_tdata[31:0]), 48'd0);
            end
            else
            begin
                want_word = expected_words.pop_front();
                words_checked++;
                if (m_tdata[31:0] !== want_word.word)
                begin
                    report_mismatch("word_out", 48'(m_tdata[31:0]), 48'(want_word.word));
                end
                if (m_tdata[34:32] !== want_word.nbytes)
                begin
                    report_mismatch("bytes_out", 48'(m_tdata[34:32]), 48'(want_word.nbytes));
                end
                if (m_tlast !== want_word.last)
                begin
                    report_mismatch("last_out", 48'(m_tlast), 48'(want_word.last));
                end
                if (m_tuser !== want_word.verdict)
                begin
                    report_mismatch("verdict", 48'(m_tuser), 48'(want_word.verdict));
                end
            end
        end
    end

    // Output side: random stalls per word, plus a long hold-off on request
    initial
    begin : rx_side
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid && rx_hold == 0) @(posedge clk);
        end
    end

    task automatic send_word(logic [31:0] word, logic [2:0] raw_bytes, logic last);
        int gap;
        s_tdata <= {{(TDATA_W - 35){1'b0}}, raw_bytes, word};
        s_tlast <= last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_transfer(word, raw_bytes, last);
        words_sent++;
        // keep tvalid high when the next word follows at once
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_frame(byte_q_t fb, bit odd_counts);
        int          nwords;
        int          nb;
        int          w;
        int          k;
        int          r;
        logic [31:0] word;
        logic [2:0]  code;
        nwords = (fb.size() + 3) / 4;
        for (w = 0; w < nwords; w++)
        begin
            word = $urandom;
            for (k = 0; k < 4; k++)
            begin
                if (4 * w + k < fb.size())
                begin
                    word[(3 - k) * 8 +: 8] = fb[4 * w + k];
                end
            end
            nb = (w == nwords - 1) ? fb.size() - 4 * w : 4;
            code = 3'(nb);
            if (odd_counts)
            begin
                if (w != nwords - 1)
                begin
                    code = 3'($urandom_range(0, 7));
                end
                else if (nb == 4)
                begin
                    // counts of 0 and 5..7 read as a full word
                    r = $urandom_range(0, 4);
                    code = (r == 0) ? 3'd0 : 3'(r + 3);
                end
            end
            send_word(word, code, w == nwords - 1);
        end
        frames_sent++;
    endtask

    task automatic build_frame(frame_kind_t kind, int ihl, int extra, bit cut,
                               output byte_q_t fb);
        int          toff;
        int          need;
        int          len;
        int          i;
        logic [15:0] port;
        logic [15:0] etype;
        logic [7:0]  proto;
        toff = 14 + 4 * ihl;
        need = (toff + 20 < 34) ? 34 : toff + 20;
        fb = {};
        for (i = 0; i < need + extra; i++)
        begin
            fb.push_back(8'($urandom));
        end
        if (kind != FK_NOISE)
        begin
            fb[12] = ETHERTYPE_IPV4[15:8];
            fb[13] = ETHERTYPE_IPV4[7:0];
            fb[14] = {4'($urandom), 4'(ihl)};
            fb[23] = PROTO_TCP;
            case (kind)
                FK_PORT_B:
                begin
                    port = port_b;
                end
                FK_OTHER_PORT:
                begin
                    port = 16'($urandom);
                    while (port == port_a || port == port_b) port = 16'($urandom);
                end
                default:
                begin
                    port = port_a;
                end
            endcase
            fb[toff + 2] = port[15:8];
            fb[toff + 3] = port[7:0];
            if (kind == FK_NOT_IPV4)
            begin
                etype = 16'($urandom);
                while (etype == ETHERTYPE_IPV4) etype = 16'($urandom);
                fb[12] = etype[15:8];
                fb[13] = etype[7:0];
            end
            if (kind == FK_NOT_TCP)
            begin
                proto = 8'($urandom);
                while (proto == PROTO_TCP) proto = 8'($urandom);
                fb[23] = proto;
            end
        end
        if (cut)
        begin
            // frame ends before the decision point
            len = $urandom_range(1, need - 1);
            while (fb.size() > len) void'(fb.pop_back());
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_CIRCUIT_OPEN: circ_open = value[0];
            REG_FALLBACK_IP:  new_ip = value[31:0];
            REG_FALLBACK_MAC: new_mac = value[47:0];
            REG_FIRST_PORT:   port_a = value[15:0];
            REG_SECOND_PORT:  port_b = value[15:0];
            default:          ;
        endcase
    endtask

    task automatic set_config(logic open, logic [31:0] ip, logic [47:0] mac,
                              logic [15:0] pa, logic [15:0] pb);
        write_reg(REG_CIRCUIT_OPEN, CFG_DW'(open));
        write_reg(REG_FALLBACK_IP, CFG_DW'(ip));
        write_reg(REG_FALLBACK_MAC, mac);
        write_reg(REG_FIRST_PORT, CFG_DW'(pa));
        write_reg(REG_SECOND_PORT, CFG_DW'(pb));
    endtask

    // Reset values: circuit closed, so even a frame to port 8000 passes
    task automatic test_closed_after_reset();
        byte_q_t fb;
        build_frame(FK_PORT_A, 5, 4, 1'b0, fb);
        send_frame(fb, 1'b0);
        build_frame(FK_PORT_B, 0, 0, 1'b0, fb);
        send_frame(fb, 1'b0);
        drain();
    endtask

    task automatic test_redirect();
        byte_q_t fb;
        set_config(1'b1, 32'h0a00_0105, 48'h0211_2233_4455, 16'd8080, 16'd50051);
        build_frame(FK_PORT_A, 5, 6, 1'b0, fb);
        send_frame(fb, 1'b0);
        // last word lands exactly on the decision point
        build_frame(FK_PORT_B, 0, 0, 1'b0, fb);
        send_frame(fb, 1'b0);
        build_frame(FK_PORT_A, 2, 3, 1'b0, fb);
        send_frame(fb, 1'b1);
        // IHL 15 fills every header cell
        build_frame(FK_PORT_B, 15, 0, 1'b0, fb);
        send_frame(fb, 1'b0);
        drain();
    endtask

    task automatic test_pass_cases();
        byte_q_t fb;
        build_frame(FK_OTHER_PORT, 0, 2, 1'b0, fb);
        send_frame(fb, 1'b0);
        build_frame(FK_NOT_IPV4, 0, 0, 1'b0, fb);
        send_frame(fb, 1'b0);
        build_frame(FK_NOT_TCP, 1, 1, 1'b0, fb);
        send_frame(fb, 1'b0);
        build_frame(FK_PORT_A, 5, 0, 1'b1, fb);
        send_frame(fb, 1'b0);
        build_frame(FK_NOISE, 0, 0, 1'b0, fb);
        send_frame(fb, 1'b1);
        drain();
        write_reg(REG_CIRCUIT_OPEN, CFG_DW'(1'b0));
        build_frame(FK_PORT_B, 0, 3, 1'b0, fb);
        send_frame(fb, 1'b0);
        drain();
    endtask

    task automatic test_extremes();
        byte_q_t fb;
        set_config(1'b1, '1, '1, 16'd0, 16'hffff);
        build_frame(FK_PORT_A, 5, 0, 1'b0, fb);
        send_frame(fb, 1'b0);
        build_frame(FK_PORT_B, 1, 5, 1'b0, fb);
        send_frame(fb, 1'b0);
        drain();
        set_config(1'b1, '0, '0, 16'hffff, 16'd0);
        build_frame(FK_PORT_A, 4, 2, 1'b0, fb);
        send_frame(fb, 1'b1);
        build_frame(FK_PORT_B, 3, 0, 1'b0, fb);
        send_frame(fb, 1'b0);
        drain();
    endtask

    task automatic random_traffic(int n_words);
        int          target;
        int          r;
        int          ihl;
        int          extra;
        frame_kind_t kind;
        byte_q_t     fb;
        target = words_sent + n_words;
        while (words_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                kind = FK_PORT_A;
            else if (r < 65)
                kind = FK_PORT_B;
            else if (r < 75)
                kind = FK_OTHER_PORT;
            else if (r < 83)
                kind = FK_NOT_IPV4;
            else if (r < 91)
                kind = FK_NOT_TCP;
            else
                kind = FK_NOISE;
            ihl = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(0, 15);
            extra = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            no_idle = ($urandom_range(0, 3) == 0);
            build_frame(kind, ihl, extra, $urandom_range(0, 9) == 0, fb);
            send_frame(fb, $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                drain();
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        int          s;
        logic [15:0] pa;
        logic [15:0] pb;
        for (s = 0; s < 3; s++)
        begin
            pa = 16'($urandom);
            pb = ($urandom_range(0, 1) == 0) ? pa : 16'($urandom);
            set_config($urandom_range(0, 5) != 0, $urandom, {16'($urandom), 32'($urandom)},
                       pa, pb);
            random_traffic(45);
            drain();
        end
    endtask

    // Hold the output long enough that a decided header waits in the cells and input stalls
    task automatic test_output_stall();
        byte_q_t fb;
        set_config(1'b1, 32'hc0a8_0a63, 48'h0a0b_0c0d_0e0f, 16'd8000, 16'd50051);
        rx_hold = 300;
        no_idle = 1'b1;
        build_frame(FK_PORT_A, 5, 40, 1'b0, fb);
        send_frame(fb, 1'b0);
        build_frame(FK_PORT_B, 5, 20, 1'b0, fb);
        send_frame(fb, 1'b0);
        build_frame(FK_OTHER_PORT, 5, 8, 1'b0, fb);
        send_frame(fb, 1'b0);
        no_idle = 1'b0;
        drain();
    endtask

    initial
    begin : main_seq
        int waited;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        held_count = 0;
        streaming = 1'b0;
        frame_verdict = VERDICT_PASS;
        circ_open = 1'b0;
        new_ip = '0;
        new_mac = '0;
        port_a = FIRST_PORT_RESET;
        port_b = SECOND_PORT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_closed_after_reset();
        test_redirect();
        test_pass_cases();
        test_extremes();
        test_random();
        test_output_stall();

        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_words.size() != 0 && waited < END_WAIT_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            report_mismatch("words never delivered", 48'(expected_words.size()), 48'd0);
        end

        $display("Sent %0d frames (%0d words), %0d of them redirected with MAC, IP and checksum",
                 frames_sent, words_sent, frames_redirected);
        $display("rewrite; %0d output words checked, %0d mismatches.", words_checked, errors);
        if (errors == 0)
        begin
            $display("tcp_port_redirect_rewriter_core_tb OK");
        end
        else
        begin
            $display("tcp_port_redirect_rewriter_core_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/rdr_pkg.sv
rtl/rdr_cell.sv
rtl/rdr_chain.sv
rtl/rdr_decide.sv
rtl/tcp_port_redirect_rewriter_core.sv
sim/tcp_port_redirect_rewriter_core_tb.sv
